[design/mer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    // default coordinate width: centre field width, pixel fields are one wider
    localparam int COORD_BITS_DEF = 10;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd3;

    // step queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    typedef struct packed {
        logic restart;
    } step_t;

    typedef enum logic [1:0] {
        PH_R1,
        PH_R2,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_SQ,
        BK_MUL_CROSS,
        BK_INIT,
        BK_INIT2,
        BK_EMIT
    } bk_state_t;

endpackage : mer_pkg
`default_nettype wire

[design/mer_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_front
// Accepts step transactions and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module mer_front import mer_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire logic  s_restart,
    output logic       q_valid,
    input  wire logic  q_ready,
    output step_t      q_item
);

    step_t               buf_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                push, pop;
    step_t               in_item;

    assign s_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = buf_reg[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        in_item.restart = s_restart;
        wr_ptr_next     = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next     = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next        = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule : mer_front
`default_nettype wire

[design/mer_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_back
// Midpoint ellipse sequencer: axis setup, region tests, incremental decision
// update spread over the four pixel slots, and the output register.
// ----------------------------------------------------------------------------
module mer_back import mer_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire step_t                        q_item,
    input  wire logic        [COORD_BITS-2:0] semi_axis_x,
    input  wire logic        [COORD_BITS-2:0] semi_axis_y,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed      [COORD_BITS:0]   m_pixel_x,
    output logic signed      [COORD_BITS:0]   m_pixel_y,
    output logic                              m_finished,
    output logic                              m_last
);

    localparam int AXIS_W = COORD_BITS - 1;
    localparam int SQ_W   = 2 * AXIS_W;
    localparam int PROD_W = 3 * AXIS_W + 1;
    localparam int DEC_W  = 3 * AXIS_W + 5;
    localparam int OUT_W  = COORD_BITS + 1;

    bk_state_t                 state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic                      fin_reg, fin_next;
    logic                      dn_reg, dn_next;
    logic [AXIS_W-1:0]         a_lat_reg, a_lat_next;
    logic [AXIS_W-1:0]         b_lat_reg, b_lat_next;
    logic [SQ_W-1:0]           aa_reg, aa_next;
    logic [SQ_W-1:0]           bb_reg, bb_next;
    logic [PROD_W-1:0]         bba_reg, bba_next;
    logic [PROD_W-1:0]         p_bx_reg, p_bx_next;
    logic [PROD_W-1:0]         p_ay_reg, p_ay_next;
    logic [COORD_BITS-1:0]     cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]     cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]     px_reg, px_next;
    logic [COORD_BITS-1:0]     py_reg, py_next;
    logic signed [DEC_W-1:0]   d_reg, d_next;
    logic signed [DEC_W-1:0]   d2_reg, d2_next;
    logic signed [DEC_W-1:0]   inc_reg, inc_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]   pix_x_reg, pix_x_next;
    logic signed [OUT_W-1:0]   pix_y_reg, pix_y_next;
    logic                      fin_out_reg, fin_out_next;
    logic                      last_reg, last_next;

    logic                      slot_free;
    logic                      take;
    logic signed [OUT_W-1:0]   cx, cy, pxe, pye;
    logic signed [OUT_W-1:0]   x_pos, x_neg, y_pos, y_neg;

    assign slot_free = !m_valid_reg || m_ready;
    assign q_ready   = (state_reg == BK_IDLE)
                    || (state_reg == BK_EMIT && cnt_reg == 2'd3 && slot_free);
    assign take      = q_valid && q_ready;

    assign m_valid    = m_valid_reg;
    assign m_pixel_x  = pix_x_reg;
    assign m_pixel_y  = pix_y_reg;
    assign m_finished = fin_out_reg;
    assign m_last     = last_reg;

    // centre is read live for every pixel
    assign cx    = {center_x[COORD_BITS-1], center_x};
    assign cy    = {center_y[COORD_BITS-1], center_y};
    assign pxe   = {1'b0, px_reg};
    assign pye   = {1'b0, py_reg};
    assign x_pos = cx + pxe;
    assign x_neg = cx - pxe;
    assign y_pos = cy + pye;
    assign y_neg = cy - pye;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        fin_next     = fin_reg;
        dn_next      = dn_reg;
        a_lat_next   = a_lat_reg;
        b_lat_next   = b_lat_reg;
        aa_next      = aa_reg;
        bb_next      = bb_reg;
        bba_next     = bba_reg;
        p_bx_next    = p_bx_reg;
        p_ay_next    = p_ay_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        d_next       = d_reg;
        d2_next      = d2_reg;
        inc_next     = inc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pix_x_next   = pix_x_reg;
        pix_y_next   = pix_y_reg;
        fin_out_next = fin_out_reg;
        last_next    = last_reg;

        unique case (state_reg)
            BK_IDLE: begin
            end
            BK_MUL_SQ: begin
                aa_next    = a_lat_reg * a_lat_reg;
                bb_next    = b_lat_reg * b_lat_reg;
                state_next = BK_MUL_CROSS;
            end
            BK_MUL_CROSS: begin
                p_ay_next  = PROD_W'(aa_reg) * PROD_W'(b_lat_reg);
                bba_next   = PROD_W'(bb_reg) * PROD_W'(a_lat_reg);
                p_bx_next  = '0;
                cur_x_next = '0;
                cur_y_next = {1'b0, b_lat_reg};
                state_next = BK_INIT;
            end
            BK_INIT: begin
                d_next     = DEC_W'(bb_reg) + DEC_W'(aa_reg >> 2);
                d2_next    = DEC_W'(aa_reg) + DEC_W'(bb_reg >> 2);
                state_next = BK_INIT2;
            end
            BK_INIT2: begin
                d_next     = d_reg - DEC_W'(p_ay_reg);
                d2_next    = d2_reg - DEC_W'(bba_reg);
                phase_next = PH_R1;
                px_next    = cur_x_reg;
                py_next    = cur_y_reg;
                cnt_next   = 2'd0;
                fin_next   = 1'b0;
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    fin_out_next = fin_reg;
                    last_next    = (cnt_reg == 2'd3);
                    if (fin_reg) begin
                        pix_x_next = '0;
                        pix_y_next = '0;
                    end else begin
                        unique case (cnt_reg)
                            2'd0: begin
                                pix_x_next = x_pos;
                                pix_y_next = y_pos;
                            end
                            2'd1: begin
                                pix_x_next = x_neg;
                                pix_y_next = y_pos;
                            end
                            2'd2: begin
                                pix_x_next = x_neg;
                                pix_y_next = y_neg;
                            end
                            2'd3: begin
                                pix_x_next = x_pos;
                                pix_y_next = y_neg;
                            end
                        endcase
                        // one piece of the iteration per pixel slot
                        unique case (cnt_reg)
                            2'd0: begin
                                dn_next = !d_reg[DEC_W-1];
                                if (phase_reg == PH_R1) begin
                                    cur_x_next = cur_x_reg + 1'b1;
                                    p_bx_next  = p_bx_reg + PROD_W'(bb_reg);
                                    if (!d_reg[DEC_W-1]) begin
                                        cur_y_next = cur_y_reg - 1'b1;
                                        p_ay_next  = p_ay_reg - PROD_W'(aa_reg);
                                    end
                                end else begin
                                    cur_y_next = cur_y_reg + 1'b1;
                                    p_ay_next  = p_ay_reg + PROD_W'(aa_reg);
                                    if (!d_reg[DEC_W-1]) begin
                                        cur_x_next = cur_x_reg - 1'b1;
                                        p_bx_next  = p_bx_reg - PROD_W'(bb_reg);
                                    end
                                end
                            end
                            2'd1: begin
                                if (phase_reg == PH_R1) begin
                                    inc_next = DEC_W'({p_bx_reg, 1'b0}) + DEC_W'(bb_reg);
                                end else begin
                                    inc_next = DEC_W'({p_ay_reg, 1'b0}) + DEC_W'(aa_reg);
                                end
                            end
                            2'd2: begin
                                if (dn_reg) begin
                                    if (phase_reg == PH_R1) begin
                                        inc_next = inc_reg - DEC_W'({p_ay_reg, 1'b0});
                                    end else begin
                                        inc_next = inc_reg - DEC_W'({p_bx_reg, 1'b0});
                                    end
                                end
                            end
                            2'd3: begin
                                d_next = d_reg + inc_reg;
                            end
                        endcase
                    end
                    if (cnt_reg == 2'd3) begin
                        state_next = BK_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        // dispatch the next step; overrides the tail of the current one
        if (take) begin
            if (q_item.restart) begin
                a_lat_next = semi_axis_x;
                b_lat_next = semi_axis_y;
                if (semi_axis_x == '0 || semi_axis_y == '0) begin
                    phase_next = PH_DONE;
                    fin_next   = 1'b1;
                    cnt_next   = 2'd3;
                    state_next = BK_EMIT;
                end else begin
                    state_next = BK_MUL_SQ;
                end
            end else begin
                priority case (phase_reg)
                    PH_R1: begin
                        fin_next   = 1'b0;
                        cnt_next   = 2'd0;
                        state_next = BK_EMIT;
                        if (p_bx_reg <= p_ay_reg) begin
                            px_next = cur_x_reg;
                            py_next = cur_y_reg;
                        end else begin
                            // switch to region 2 at (a, 0)
                            phase_next = PH_R2;
                            cur_x_next = {1'b0, a_lat_reg};
                            cur_y_next = '0;
                            p_bx_next  = bba_reg;
                            p_ay_next  = '0;
                            d_next     = d2_reg;
                            px_next    = {1'b0, a_lat_reg};
                            py_next    = '0;
                        end
                    end
                    PH_R2: begin
                        state_next = BK_EMIT;
                        if (p_bx_reg > p_ay_reg) begin
                            px_next  = cur_x_reg;
                            py_next  = cur_y_reg;
                            fin_next = 1'b0;
                            cnt_next = 2'd0;
                        end else begin
                            phase_next = PH_DONE;
                            fin_next   = 1'b1;
                            cnt_next   = 2'd3;
                        end
                    end
                    default: begin
                        fin_next   = 1'b1;
                        cnt_next   = 2'd3;
                        state_next = BK_EMIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            phase_reg   <= PH_DONE;
            cnt_reg     <= 2'd0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dn_reg      <= dn_next;
        a_lat_reg   <= a_lat_next;
        b_lat_reg   <= b_lat_next;
        aa_reg      <= aa_next;
        bb_reg      <= bb_next;
        bba_reg     <= bba_next;
        p_bx_reg    <= p_bx_next;
        p_ay_reg    <= p_ay_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        d_reg       <= d_next;
        d2_reg      <= d2_next;
        inc_reg     <= inc_next;
        pix_x_reg   <= pix_x_next;
        pix_y_reg   <= pix_y_next;
        fin_out_reg <= fin_out_next;
        last_reg    <= last_next;
    end

    // region 1 only emits points that passed its slope test
    a_r1_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EMIT && !fin_reg && cnt_reg == 2'd0 && phase_reg == PH_R1)
        |-> (p_bx_reg <= p_ay_reg))
        else $error("region 1 pixel emitted past the slope change");

    // region 2 only emits points that passed its slope test
    a_r2_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EMIT && !fin_reg && cnt_reg == 2'd0 && phase_reg == PH_R2)
        |-> (p_bx_reg > p_ay_reg))
        else $error("region 2 pixel emitted past its end");

    // a finished step occupies only the last slot
    a_fin_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EMIT && fin_reg) |-> (cnt_reg == 2'd3))
        else $error("finished transaction scheduled in a pixel slot");

    // a finished result carries no pixel and closes its step
    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && fin_out_reg)
        |-> (pix_x_reg == '0 && pix_y_reg == '0 && last_reg))
        else $error("finished result carries pixel data");

endmodule : mer_back
`default_nettype wire

[design/midpoint_ellipse_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Integer midpoint ellipse rasterizer with a step queue and one output slot.
// ----------------------------------------------------------------------------
// Usage:
//   Write the semi-axes and the centre over the cfg_* channel (always ready)
//   while the block is idle. Each s_* transaction is one step; s_restart set
//   latches the axes and starts at region 1 (finished if an axis is zero).
//   Every step returns four symmetric pixels on m_*, the fourth with m_last,
//   or one result with m_finished and m_last once the ellipse is complete.
//   Throughput: one pixel per cycle while m_ready is high and steps are
//   queued; the four pixel slots carry the incremental decision update in
//   pieces. A restart first passes the setup states BK_MUL_SQ, BK_MUL_CROSS
//   (axis squares, cross products), BK_INIT and BK_INIT2; the switch to
//   region 2 is made at dispatch and adds no state. A continuing step goes
//   from the queue straight to BK_EMIT; each pixel is registered on m_*.
//   A two-entry queue keeps accepting steps while the output register waits.
//   When m_ready is low the result holds and the sequencer stalls.
//   Reset leaves the drawing complete: steps without restart return finished.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_restart,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_BITS:0]         m_pixel_x,
    output logic signed [COORD_BITS:0]         m_pixel_y,
    output logic                               m_finished,
    output logic                               m_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [COORD_BITS-1:0]  cfg_data
);

    logic        [COORD_BITS-2:0] semi_x_reg;
    logic        [COORD_BITS-2:0] semi_y_reg;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;

    logic  q_valid;
    logic  q_ready;
    step_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            semi_x_reg   <= (COORD_BITS-1)'(1);
            semi_y_reg   <= (COORD_BITS-1)'(1);
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SEMI_AXIS_X: semi_x_reg   <= cfg_data[COORD_BITS-2:0];
                CFG_SEMI_AXIS_Y: semi_y_reg   <= cfg_data[COORD_BITS-2:0];
                CFG_CENTER_X:    center_x_reg <= cfg_data;
                CFG_CENTER_Y:    center_y_reg <= cfg_data;
            endcase
        end
    end

    mer_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    mer_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .semi_axis_x (semi_x_reg),
        .semi_axis_y (semi_y_reg),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_x   (m_pixel_x),
        .m_pixel_y   (m_pixel_y),
        .m_finished  (m_finished),
        .m_last      (m_last)
    );

endmodule : midpoint_ellipse_rasterizer
`default_nettype wire
